FILE: rtl/core/ray_box_slab_test_macros.svh
// Assertion macros for the ray box slab test RTL, used by rbst_ctrl.
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define RBST_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("rbst assertion failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define RBST_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("rbst assertion failed");

`endif

FILE: rtl/core/rbst_pkg.sv
// Shared widths and types for the ray box slab test pipeline.
`timescale 1ns / 1ps
package rbst_pkg;

    localparam int CoordW    = 32;
    localparam int DiffW     = CoordW + 1;
    localparam int DistW     = 2 * CoordW;
    localparam int NumFields = 12;
    localparam int TdataInW  = NumFields * CoordW;
    localparam int TdataOutW = 8;
    localparam int NumStages = 6;

    localparam int StgDiff   = 0;
    localparam int StgMul    = 1;
    localparam int StgOrder  = 2;
    localparam int StgPair   = 3;
    localparam int StgAll    = 4;
    localparam int StgOut    = 5;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [DiffW-1:0]  diff_t;
    typedef logic signed [DistW-1:0]  dist_t;

    typedef struct packed {
        logic [NumStages-1:0] en;
    } rbst_ctrl_t;

endpackage

FILE: rtl/core/rbst_ctrl.sv
// Valid chain and per-stage load enables for the slab test pipeline.
`timescale 1ns / 1ps
`include "ray_box_slab_test_macros.svh"
module rbst_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output rbst_pkg::rbst_ctrl_t ctrl
);

    logic [rbst_pkg::NumStages-1:0] valid_reg;
    logic [rbst_pkg::NumStages-1:0] valid_next;
    logic [rbst_pkg::NumStages-1:0] valid_in;
    logic [rbst_pkg::NumStages:0]   rdy;

    always_comb begin
        rdy[rbst_pkg::NumStages] = m_tready;
        for (int i = rbst_pkg::NumStages - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign valid_in   = {valid_reg[rbst_pkg::NumStages-2:0], s_tvalid};
    assign valid_next = (rdy[rbst_pkg::NumStages-1:0] & valid_in)
                      | (~rdy[rbst_pkg::NumStages-1:0] & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready   = rdy[0];
    assign m_tvalid   = valid_reg[rbst_pkg::NumStages-1];
    assign ctrl.en    = rdy[rbst_pkg::NumStages-1:0];

    `RBST_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, valid_reg[0])
    `RBST_ASSERT_IMPL(a_ready_chain, ctrl.en[rbst_pkg::NumStages-1], s_tready)
    `RBST_ASSERT_NEXT(a_out_drains,
        m_tvalid && m_tready && !valid_reg[rbst_pkg::NumStages-2], !m_tvalid)

endmodule

FILE: rtl/core/rbst_axis.sv
// One axis of the slab test: slab offsets, slab distances, near/far order.
`timescale 1ns / 1ps
module rbst_axis (
    input  logic                 aclk,
    input  rbst_pkg::rbst_ctrl_t ctrl,
    input  rbst_pkg::coord_t     origin,
    input  rbst_pkg::coord_t     inv_dir,
    input  rbst_pkg::coord_t     box_min,
    input  rbst_pkg::coord_t     box_max,
    output rbst_pkg::dist_t      t_near,
    output rbst_pkg::dist_t      t_far,
    output logic                 in_box
);

    rbst_pkg::diff_t  d_lo_reg, d_hi_reg, d_lo_next, d_hi_next;
    rbst_pkg::coord_t inv_reg;
    logic             in1_reg, in2_reg, in3_reg, in1_next;

    logic signed [rbst_pkg::DiffW+rbst_pkg::CoordW-1:0] prod_lo, prod_hi;
    rbst_pkg::dist_t  t_lo_reg, t_hi_reg;
    rbst_pkg::dist_t  near_reg, far_reg, near_next, far_next;

    assign d_lo_next = rbst_pkg::DiffW'(box_min) - rbst_pkg::DiffW'(origin);
    assign d_hi_next = rbst_pkg::DiffW'(box_max) - rbst_pkg::DiffW'(origin);
    assign in1_next  = (origin >= box_min) && (origin <= box_max);

    always_ff @(posedge aclk) begin
        if (ctrl.en[rbst_pkg::StgDiff]) begin
            d_lo_reg <= d_lo_next;
            d_hi_reg <= d_hi_next;
            inv_reg  <= inv_dir;
            in1_reg  <= in1_next;
        end
    end

    assign prod_lo = d_lo_reg * inv_reg;
    assign prod_hi = d_hi_reg * inv_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[rbst_pkg::StgMul]) begin
            t_lo_reg <= prod_lo[rbst_pkg::DistW-1:0];
            t_hi_reg <= prod_hi[rbst_pkg::DistW-1:0];
            in2_reg  <= in1_reg;
        end
    end

    assign near_next = (t_lo_reg < t_hi_reg) ? t_lo_reg : t_hi_reg;
    assign far_next  = (t_lo_reg < t_hi_reg) ? t_hi_reg : t_lo_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[rbst_pkg::StgOrder]) begin
            near_reg <= near_next;
            far_reg  <= far_next;
            in3_reg  <= in2_reg;
        end
    end

    assign t_near = near_reg;
    assign t_far  = far_reg;
    assign in_box = in3_reg;

endmodule

FILE: rtl/core/rbst_reduce.sv
// Entry/exit reduction across axes and the final hit decision.
`timescale 1ns / 1ps
module rbst_reduce (
    input  logic                 aclk,
    input  rbst_pkg::rbst_ctrl_t ctrl,
    input  rbst_pkg::dist_t      near_x,
    input  rbst_pkg::dist_t      far_x,
    input  rbst_pkg::dist_t      near_y,
    input  rbst_pkg::dist_t      far_y,
    input  rbst_pkg::dist_t      near_z,
    input  rbst_pkg::dist_t      far_z,
    input  logic [2:0]           inside_axes,
    output logic                 hit,
    output logic                 origin_inside
);

    rbst_pkg::dist_t entry_xy_reg, exit_xy_reg, near_z_reg, far_z_reg;
    rbst_pkg::dist_t entry_xy_next, exit_xy_next;
    rbst_pkg::dist_t entry_reg, exit_reg, entry_next, exit_next;
    logic            in4_reg, in5_reg, hit_reg, inside_reg, hit_next;

    assign entry_xy_next = (near_y > near_x) ? near_y : near_x;
    assign exit_xy_next  = (far_y < far_x) ? far_y : far_x;

    always_ff @(posedge aclk) begin
        if (ctrl.en[rbst_pkg::StgPair]) begin
            entry_xy_reg <= entry_xy_next;
            exit_xy_reg  <= exit_xy_next;
            near_z_reg   <= near_z;
            far_z_reg    <= far_z;
            in4_reg      <= &inside_axes;
        end
    end

    assign entry_next = (near_z_reg > entry_xy_reg) ? near_z_reg : entry_xy_reg;
    assign exit_next  = (far_z_reg < exit_xy_reg) ? far_z_reg : exit_xy_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[rbst_pkg::StgAll]) begin
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
            in5_reg   <= in4_reg;
        end
    end

    assign hit_next = in5_reg || (exit_reg >= entry_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.en[rbst_pkg::StgOut]) begin
            hit_reg    <= hit_next;
            inside_reg <= in5_reg;
        end
    end

    assign hit           = hit_reg;
    assign origin_inside = inside_reg;

endmodule

FILE: rtl/core/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test pipeline.
// Each test passes the Diff, Mul, Order, Pair, All and Out registers in that order.
// Throughput: one test per cycle while m_tready is high; each of the six register stages advances
// where the downstream stage is free, so bubbles collapse under back-pressure.
// Reset: aresetn low clears every stage valid bit; data registers are not reset.
`timescale 1ns / 1ps
module ray_box_slab_test (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [rbst_pkg::TdataInW-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, origin_inside, zero fill
    output logic [rbst_pkg::TdataOutW-1:0] m_tdata
);

    localparam int W = rbst_pkg::CoordW;

    rbst_pkg::rbst_ctrl_t ctrl;
    rbst_pkg::coord_t     org [3];
    rbst_pkg::coord_t     inv [3];
    rbst_pkg::coord_t     bmin [3];
    rbst_pkg::coord_t     bmax [3];
    rbst_pkg::dist_t      t_near [3];
    rbst_pkg::dist_t      t_far [3];
    logic [2:0]           inside_axes;
    logic                 hit;
    logic                 origin_inside;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            org[a]  = s_tdata[a*W +: W];
            inv[a]  = s_tdata[(3 + a)*W +: W];
            bmin[a] = s_tdata[(6 + a)*W +: W];
            bmax[a] = s_tdata[(9 + a)*W +: W];
        end
    end

    rbst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbst_axis u_axis (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .origin  (org[a]),
            .inv_dir (inv[a]),
            .box_min (bmin[a]),
            .box_max (bmax[a]),
            .t_near  (t_near[a]),
            .t_far   (t_far[a]),
            .in_box  (inside_axes[a])
        );
    end

    rbst_reduce u_reduce (
        .aclk          (aclk),
        .ctrl          (ctrl),
        .near_x        (t_near[0]),
        .far_x         (t_far[0]),
        .near_y        (t_near[1]),
        .far_y         (t_far[1]),
        .near_z        (t_near[2]),
        .far_z         (t_far[2]),
        .inside_axes   (inside_axes),
        .hit           (hit),
        .origin_inside (origin_inside)
    );

    assign m_tdata = {(rbst_pkg::TdataOutW - 2)'(0), origin_inside, hit};

endmodule

FILE: test/ray_box_slab_test_test.sv
// Self-checking testbench for the ray versus axis-aligned box slab test pipeline.
`timescale 1ns / 1ps
module ray_box_slab_test_test;

    typedef rbst_pkg::coord_t coord_t;
    typedef rbst_pkg::dist_t  dist_t;

    localparam int ClkPeriod     = 4;
    localparam int ResetCycles   = 4;
    localparam int NumRandom     = 1400;
    localparam int IdlePercent   = 12;
    localparam int BurstFrom     = 600;
    localparam int BurstTo       = 800;
    localparam int HoldAt        = 300;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 20;
    localparam int WatchdogLimit = 2000;
    localparam int TdataInW      = rbst_pkg::TdataInW;
    localparam int TdataOutW     = rbst_pkg::TdataOutW;

    localparam coord_t Zero = 32'sh0000_0000;
    localparam coord_t One  = 32'sh0001_0000;
    localparam coord_t MaxC = 32'sh7FFF_FFFF;
    localparam coord_t MinC = 32'sh8000_0000;

    // x in the lowest bits of each group, origin group lowest
    typedef struct packed {
        coord_t [2:0] hi;
        coord_t [2:0] lo;
        coord_t [2:0] inv;
        coord_t [2:0] org;
    } ray_box_t;

    typedef struct packed {
        logic in_box;
        logic hit;
    } slab_result_t;

    typedef struct packed {
        ray_box_t     rb;
        logic         fixed;
        slab_result_t want;
    } test_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [TdataInW-1:0]   s_tdata  = '0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire  [TdataOutW-1:0]  m_tdata;

    test_row_t    tests[$];
    slab_result_t expected_results[$];
    int           mismatches   = 0;
    int           received     = 0;
    int           idle_cycles  = 0;
    bit           sending_done = 1'b0;

    ray_box_slab_test dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(ClkPeriod / 2) aclk = ~aclk;

    function automatic slab_result_t slab_predict(ray_box_t rb);
        slab_result_t res;
        coord_t       o, d, l, h;
        dist_t        t1, t2, near_d, far_d, enter_d, leave_d;
        int           a;
        res.hit    = 1'b1;
        res.in_box = 1'b1;
        enter_d    = '0;
        leave_d    = '0;
        for (a = 0; a < 3; a++) begin
            o = rb.org[a];
            l = rb.lo[a];
            h = rb.hi[a];
            if (o < l || o > h) res.in_box = 1'b0;
        end
        if (res.in_box) return res;
        for (a = 0; a < 3; a++) begin
            o = rb.org[a];
            d = rb.inv[a];
            l = rb.lo[a];
            h = rb.hi[a];
            t1 = (dist_t'(l) - dist_t'(o)) * dist_t'(d);
            t2 = (dist_t'(h) - dist_t'(o)) * dist_t'(d);
            near_d = (t1 < t2) ? t1 : t2;
            far_d  = (t1 < t2) ? t2 : t1;
            if (a == 0 || near_d > enter_d) enter_d = near_d;
            if (a == 0 || far_d < leave_d) leave_d = far_d;
        end
        res.hit = (leave_d >= enter_d);
        return res;
    endfunction

    function automatic ray_box_t box_of(coord_t ox, coord_t oy, coord_t oz,
                                        coord_t ix, coord_t iy, coord_t iz,
                                        coord_t lx, coord_t ly, coord_t lz,
                                        coord_t hx, coord_t hy, coord_t hz);
        ray_box_t rb;
        rb.org[0] = ox; rb.org[1] = oy; rb.org[2] = oz;
        rb.inv[0] = ix; rb.inv[1] = iy; rb.inv[2] = iz;
        rb.lo[0]  = lx; rb.lo[1]  = ly; rb.lo[2]  = lz;
        rb.hi[0]  = hx; rb.hi[1]  = hy; rb.hi[2]  = hz;
        return rb;
    endfunction

    function automatic void add_row(ray_box_t rb, bit fixed, bit hit, bit in_box);
        test_row_t row;
        row.rb          = rb;
        row.fixed       = fixed;
        row.want.hit    = hit;
        row.want.in_box = in_box;
        tests.push_back(row);
    endfunction

    function automatic coord_t small_coord();
        return coord_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    function automatic coord_t any_coord();
        case ($urandom_range(0, 7))
            0: return MaxC;
            1: return MinC;
            2: return Zero;
            3: return -One;
            4: return small_coord();
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic ray_box_t random_ray_box();
        ray_box_t rb;
        coord_t   o, d, l, h, t;
        int       roll, a;
        roll = $urandom_range(0, 99);
        for (a = 0; a < 3; a++) begin
            if (roll < 20) begin
                l = small_coord();
                h = l + coord_t'($urandom_range(0, 32'h0004_0000));
                o = l + coord_t'($urandom_range(0, h - l));
                d = small_coord();
            end else if (roll < 60) begin
                o = small_coord();
                l = small_coord();
                h = small_coord();
                if (l > h && $urandom_range(0, 9) != 0) begin
                    t = l;
                    l = h;
                    h = t;
                end
                case ($urandom_range(0, 9))
                    0: d = Zero;
                    1: d = MaxC;
                    2: d = MinC;
                    default: d = small_coord();
                endcase
            end else if (roll < 80) begin
                o = coord_t'($urandom);
                d = coord_t'($urandom);
                l = coord_t'($urandom);
                h = coord_t'($urandom);
            end else begin
                o = any_coord();
                d = any_coord();
                l = any_coord();
                h = any_coord();
            end
            rb.org[a] = o;
            rb.inv[a] = d;
            rb.lo[a]  = l;
            rb.hi[a]  = h;
        end
        return rb;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", received, what, got, want);
        mismatches++;
    endtask

    initial begin : run_control
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(sending_done && expected_results.size() == 0)) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : drive_tests
        int idx;
        bit accepted;
        // origin inside or on the box
        add_row(box_of(Zero, Zero, Zero, One, One, One,
                       -One, -One, -One, One, One, One), 1, 1, 1);
        add_row(box_of(-One, Zero, Zero, One, One, One,
                       -One, -One, -One, One, One, One), 1, 1, 1);
        add_row(box_of(One, One, One, MinC, Zero, MaxC,
                       -One, -One, -One, One, One, One), 1, 1, 1);
        add_row(box_of(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC,
                       MaxC, MaxC, MaxC, MaxC, MaxC, MaxC), 1, 1, 1);
        add_row(box_of(MinC, MinC, MinC, MinC, MinC, MinC,
                       MinC, MinC, MinC, MinC, MinC, MinC), 1, 1, 1);
        add_row(box_of(Zero, MaxC, MinC, Zero, Zero, Zero,
                       MinC, MinC, MinC, MaxC, MaxC, MaxC), 1, 1, 1);
        // zero inverse on every axis, origin outside
        add_row(box_of(2 * One, Zero, Zero, Zero, Zero, Zero,
                       -One, -One, -One, One, One, One), 1, 1, 0);
        // slab cases
        add_row(box_of(-4 * One, Zero, Zero, One, MaxC, MaxC,
                       -One, -One, -One, One, One, One), 0, 0, 0);
        add_row(box_of(-4 * One, 3 * One, Zero, One, MaxC, MaxC,
                       -One, -One, -One, One, One, One), 0, 0, 0);
        add_row(box_of(4 * One, Zero, Zero, One, MaxC, MaxC,
                       -One, -One, -One, One, One, One), 0, 0, 0);
        add_row(box_of(-4 * One, Zero, Zero, One, MaxC, MaxC,
                       One, -One, -One, -One, One, One), 0, 0, 0);
        add_row(box_of(-2 * One, -2 * One, -2 * One, MinC, MinC, MinC,
                       -One, -One, -One, One, One, One), 0, 0, 0);
        add_row(box_of(MinC, MinC, MinC, MinC, MinC, MinC,
                       MaxC, MaxC, MaxC, MaxC, MaxC, MaxC), 0, 0, 0);
        add_row(box_of(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC,
                       MinC, MinC, MinC, MinC, MinC, MinC), 0, 0, 0);
        add_row(box_of(MinC, Zero, Zero, MaxC, MinC, Zero,
                       MaxC, MinC, One, MaxC, MinC, MaxC), 0, 0, 0);
        // grazing: entry equals exit, then just past the corner, then other slab cases
        add_row(box_of(-One, Zero, Zero, One, -One, MaxC,
                       Zero, -3 * One, -One, One, -2 * One, One), 0, 0, 0);
        add_row(box_of(-One, Zero, Zero, One, -One, MaxC,
                       Zero, -4 * One, -One, One, -3 * One, One), 0, 0, 0);
        add_row(box_of(-One, Zero, Zero, One, -One, MaxC,
                       Zero, -2 * One, -One, One, -One, One), 0, 0, 0);
        add_row(box_of(Zero, 5 * One, Zero, Zero, -One, Zero,
                       -One, -One, -One, One, One, One), 0, 0, 0);
        add_row(box_of(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                       32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                       32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                       32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555), 0, 0, 0);
        for (idx = 0; idx < NumRandom; idx++)
            add_row(random_ray_box(), 0, 0, 0);

        while (!aresetn) @(posedge aclk);
        for (idx = 0; idx < tests.size(); idx++) begin
            while (!(idx >= BurstFrom && idx < BurstTo) &&
                   $urandom_range(0, 99) < IdlePercent) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= tests[idx].rb;
            do begin
                @(negedge aclk);
                accepted = s_tready;
                @(posedge aclk);
            end while (!accepted);
            if (tests[idx].fixed)
                expected_results.push_back(tests[idx].want);
            else
                expected_results.push_back(slab_predict(tests[idx].rb));
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin : drive_ready
        bit held;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && received >= HoldAt) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end else begin
                m_tready <= (received >= BurstFrom && received < BurstTo) ||
                            ($urandom_range(0, 99) >= IdlePercent);
                @(posedge aclk);
            end
        end
    end

    // sample at the falling edge; inputs only change at the rising edge
    always @(negedge aclk) begin : check_results
        slab_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("transfer with nothing expected", m_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report_mismatch("hit", m_tdata[0], want.hit);
                    if (m_tdata[1] !== want.in_box)
                        report_mismatch("origin_inside", m_tdata[1], want.in_box);
                end
                received++;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WatchdogLimit) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

endmodule
